// ===== src/wmf_pkg.sv =====
// Shared types and constants of the windowed median filter.
package wmf_pkg;
    localparam int MAX_WIDTH   = 64;
    localparam int MAX_HEIGHT  = 64;
    localparam int MAX_HALF    = 7;
    localparam int SAMPLE_BITS = 16;

    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 7;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_IMAGE_WIDTH  = 2'd0,
        REG_IMAGE_HEIGHT = 2'd1,
        REG_HALF_WIDTH   = 2'd2,
        REG_HALF_HEIGHT  = 2'd3
    } t_reg_idx;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_QUERY = 1'b1
    } t_opcode;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SETUP,
        ST_RANK_INIT,
        ST_BIT_INIT,
        ST_SCAN,
        ST_SCAN_WAIT,
        ST_BIT_DONE,
        ST_NEXT_RANK,
        ST_FINISH,
        ST_OUT
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic take_item;
        logic do_write;
        logic setup;
        logic bit_init;
        logic scan_start;
        logic scan_step;
        logic bit_decide;
        logic next_rank;
        logic finish;
        logic out_load;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic is_query;
        logic scan_last;
        logic last_bit;
        logic two_ranks;
        logic second_done;
    } t_status;
endpackage

// ===== src/wmf_if.sv =====
// Valid/ready channel interface carrying a payload.
interface wmf_if #(parameter int WIDTH = 1);
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== src/wmf_ctrl.sv =====
// Controller state machine of the windowed median filter.
module wmf_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  wmf_pkg::t_status  i_status,
    output wmf_pkg::t_cmd     o_cmd
);
    wmf_pkg::t_state r_state, n_state;
    logic r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= wmf_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            wmf_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.take_item = 1'b1;
                    n_state = wmf_pkg::ST_SETUP;
                end
            end
            wmf_pkg::ST_SETUP: begin
                if (i_status.is_query) begin
                    o_cmd.setup = 1'b1;
                    n_state = wmf_pkg::ST_RANK_INIT;
                end else begin
                    o_cmd.do_write = 1'b1;
                    n_state = wmf_pkg::ST_IDLE;
                end
            end
            wmf_pkg::ST_RANK_INIT: begin
                o_cmd.bit_init = 1'b1;
                n_state = wmf_pkg::ST_BIT_INIT;
            end
            wmf_pkg::ST_BIT_INIT: begin
                o_cmd.scan_start = 1'b1;
                n_state = wmf_pkg::ST_SCAN;
            end
            wmf_pkg::ST_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_status.scan_last) begin
                    n_state = wmf_pkg::ST_SCAN_WAIT;
                end
            end
            wmf_pkg::ST_SCAN_WAIT: begin
                n_state = wmf_pkg::ST_BIT_DONE;
            end
            wmf_pkg::ST_BIT_DONE: begin
                o_cmd.bit_decide = 1'b1;
                if (i_status.last_bit) begin
                    n_state = wmf_pkg::ST_NEXT_RANK;
                end else begin
                    n_state = wmf_pkg::ST_BIT_INIT;
                end
            end
            wmf_pkg::ST_NEXT_RANK: begin
                if (i_status.two_ranks && !i_status.second_done) begin
                    o_cmd.next_rank = 1'b1;
                    o_cmd.bit_init  = 1'b1;
                    n_state = wmf_pkg::ST_BIT_INIT;
                end else begin
                    o_cmd.finish = 1'b1;
                    n_state = wmf_pkg::ST_FINISH;
                end
            end
            wmf_pkg::ST_FINISH: begin
                n_state = wmf_pkg::ST_OUT;
            end
            wmf_pkg::ST_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid = 1'b1;
                    n_state = wmf_pkg::ST_IDLE;
                end
            end
            default: n_state = wmf_pkg::ST_IDLE;
        endcase
    end

    assign o_out_valid = r_out_valid;
endmodule

// ===== src/wmf_datapath.sv =====
// Datapath: image store, window scan and bitwise rank selection.
module wmf_datapath #(
    parameter int SAMPLE_BITS = wmf_pkg::SAMPLE_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [wmf_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [wmf_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    input  logic                          i_opcode,
    input  logic [5:0]                    i_col,
    input  logic [5:0]                    i_row,
    input  logic signed [SAMPLE_BITS-1:0] i_pixel_value,
    input  wmf_pkg::t_cmd                 i_cmd,
    output wmf_pkg::t_status              o_status,
    output logic signed [SAMPLE_BITS-1:0] o_median_value,
    output logic [7:0]                    o_window_count
);
    localparam int MAX_WIDTH  = wmf_pkg::MAX_WIDTH;
    localparam int MAX_HEIGHT = wmf_pkg::MAX_HEIGHT;
    localparam int MAX_HALF   = wmf_pkg::MAX_HALF;
    localparam int XW    = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
    localparam int YW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = XW + YW;
    localparam int BW    = $clog2(SAMPLE_BITS);
    localparam int WSIDE = 2 * MAX_HALF + 1;
    localparam int CW    = $clog2(WSIDE * WSIDE + 1);

    logic [6:0] r_img_w, r_img_h;
    logic [2:0] r_half_w, r_half_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w  <= 7'd64;
            r_img_h  <= 7'd64;
            r_half_w <= 3'd1;
            r_half_h <= 3'd1;
        end else if (i_cfg_we) begin
            unique case (wmf_pkg::t_reg_idx'(i_cfg_idx))
                wmf_pkg::REG_IMAGE_WIDTH: r_img_w <= (i_cfg_data == 7'd0) ? 7'd1 :
                    (i_cfg_data > 7'(MAX_WIDTH)) ? 7'(MAX_WIDTH) : i_cfg_data;
                wmf_pkg::REG_IMAGE_HEIGHT: r_img_h <= (i_cfg_data == 7'd0) ? 7'd1 :
                    (i_cfg_data > 7'(MAX_HEIGHT)) ? 7'(MAX_HEIGHT) : i_cfg_data;
                wmf_pkg::REG_HALF_WIDTH: r_half_w <= (i_cfg_data[2:0] > 3'(MAX_HALF)) ?
                    3'(MAX_HALF) : i_cfg_data[2:0];
                wmf_pkg::REG_HALF_HEIGHT: r_half_h <= (i_cfg_data[2:0] > 3'(MAX_HALF)) ?
                    3'(MAX_HALF) : i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // latched item
    logic                          r_op;
    logic [6:0]                    r_x, r_y;
    logic signed [SAMPLE_BITS-1:0] r_wdata;
    always_ff @(posedge i_clk) begin
        if (i_cmd.take_item) begin
            r_op    <= i_opcode;
            r_x     <= ({1'b0, i_col} > r_img_w - 7'd1) ? r_img_w - 7'd1 : {1'b0, i_col};
            r_y     <= ({1'b0, i_row} > r_img_h - 7'd1) ? r_img_h - 7'd1 : {1'b0, i_row};
            r_wdata <= i_pixel_value;
        end
    end

    // window bounds
    logic [7:0] w_x1, w_y1;
    logic [6:0] r_x0, r_y0, r_x1, r_y1;
    assign w_x1 = {1'b0, r_x} + 8'(r_half_w);
    assign w_y1 = {1'b0, r_y} + 8'(r_half_h);
    always_ff @(posedge i_clk) begin
        if (i_cmd.setup) begin
            r_x0 <= (r_x > 7'(r_half_w)) ? r_x - 7'(r_half_w) : 7'd0;
            r_y0 <= (r_y > 7'(r_half_h)) ? r_y - 7'(r_half_h) : 7'd0;
            r_x1 <= (w_x1 > 8'(r_img_w) - 8'd1) ? r_img_w - 7'd1 : w_x1[6:0];
            r_y1 <= (w_y1 > 8'(r_img_h) - 8'd1) ? r_img_h - 7'd1 : w_y1[6:0];
        end
    end

    logic [CW-1:0] w_cnt;
    logic [7:0]    w_wx, w_wy;
    assign w_wx  = 8'(r_x1) - 8'(r_x0) + 8'd1;
    assign w_wy  = 8'(r_y1) - 8'(r_y0) + 8'd1;
    assign w_cnt = CW'(w_wx * w_wy);

    // image memory
    logic signed [SAMPLE_BITS-1:0] r_mem [DEPTH];
    logic signed [SAMPLE_BITS-1:0] r_rdata;
    logic [6:0] r_sx, r_sy;
    logic [AW-1:0] w_raddr, w_waddr;
    assign w_raddr = {r_sy[YW-1:0], r_sx[XW-1:0]};
    assign w_waddr = {r_y[YW-1:0], r_x[XW-1:0]};
    always_ff @(posedge i_clk) begin
        if (i_cmd.do_write) begin
            r_mem[w_waddr] <= r_wdata;
        end
        r_rdata <= r_mem[w_raddr];
    end

    // scan counters: one pixel per cycle, data the cycle after its address
    logic r_rvalid;
    assign o_status.scan_last = (r_sx == r_x1) && (r_sy == r_y1);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rvalid <= 1'b0;
        end else begin
            r_rvalid <= i_cmd.scan_step;
        end
        if (i_cmd.scan_start) begin
            r_sx <= r_x0;
            r_sy <= r_y0;
        end else if (i_cmd.scan_step) begin
            if (r_sx == r_x1) begin
                r_sx <= r_x0;
                r_sy <= r_sy + 7'd1;
            end else begin
                r_sx <= r_sx + 7'd1;
            end
        end
    end

    // bitwise selection of k-th smallest (offset-binary prefix search)
    logic [SAMPLE_BITS-1:0] r_prefix;
    logic [BW-1:0]          r_bit;
    logic [CW-1:0]          r_k, r_zeros;
    logic                   r_second;
    logic [SAMPLE_BITS-1:0] r_first;
    logic [SAMPLE_BITS-1:0] w_key, w_mask;
    assign w_key   = r_rdata ^ {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    assign w_mask  = {SAMPLE_BITS{1'b1}} << r_bit;

    assign o_status.last_bit    = (r_bit == '0);
    assign o_status.two_ranks   = ~w_cnt[0];
    assign o_status.second_done = r_second;
    assign o_status.is_query    = (r_op == wmf_pkg::OP_QUERY);

    always_ff @(posedge i_clk) begin
        if (i_cmd.bit_init) begin
            r_bit    <= BW'(SAMPLE_BITS - 1);
            r_prefix <= '0;
            if (!i_cmd.next_rank) begin
                r_second <= 1'b0;
                r_k      <= w_cnt[0] ? CW'(w_cnt >> 1) : CW'((w_cnt >> 1) - 1);
            end else begin
                r_second <= 1'b1;
                r_first  <= r_prefix;
                r_k      <= CW'(w_cnt >> 1);
            end
        end
        if (i_cmd.scan_start) begin
            r_zeros <= '0;
        end else if (r_rvalid) begin
            if (((w_key ^ r_prefix) & w_mask) == '0) begin
                r_zeros <= r_zeros + CW'(1);
            end
        end
        if (i_cmd.bit_decide) begin
            if (r_k >= r_zeros) begin
                r_prefix[r_bit] <= 1'b1;
                r_k <= r_k - r_zeros;
            end
            if (r_bit != '0) begin
                r_bit <= r_bit - BW'(1);
            end
        end
    end

    logic signed [SAMPLE_BITS:0] r_sum;
    logic signed [SAMPLE_BITS-1:0] w_a, w_b;
    assign w_a = r_first ^ {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    assign w_b = r_prefix ^ {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            if (r_second) begin
                r_sum <= (SAMPLE_BITS+1)'(w_a) + (SAMPLE_BITS+1)'(w_b);
            end else begin
                r_sum <= {w_b, 1'b0};
            end
        end
        if (i_cmd.out_load) begin
            o_median_value <= r_sum[SAMPLE_BITS:1];
            o_window_count <= 8'(w_cnt);
        end
    end
endmodule

// ===== src/windowed_median_filter_2d.sv =====
// Top level of the windowed median filter.
// Input channel: write items (opcode 0) store a pixel, query items (opcode 1)
// return one result item with the median and pixel count of the clipped
// window around the pixel. Write items return nothing.
// A query scans the window from the image memory once per result bit, twice
// per bit for an even count, one pixel per cycle; the single read port of
// the image memory sets this rate. One item is worked at a time.
// The result sits in an output register; the next item is taken while it
// waits, and a query that finishes before the receiver takes the first
// result holds in its output state until it does.
// Reset clears control state and sets the registers to 64x64 image size and
// half extents of 1. The image memory is not cleared; pixels must be written
// before a query covers them. Configuration writes are allowed while idle.
module windowed_median_filter_2d #(
    parameter int SAMPLE_BITS = wmf_pkg::SAMPLE_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [wmf_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [wmf_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    wmf_if.sink                               in_ch,
    wmf_if.source                             out_ch
);
    wmf_pkg::t_cmd    w_cmd;
    wmf_pkg::t_status w_status;
    logic signed [SAMPLE_BITS-1:0] w_med;
    logic [7:0] w_cnt;

    wmf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_ch.valid),
        .o_in_ready  (in_ch.ready),
        .o_out_valid (out_ch.valid),
        .i_out_ready (out_ch.ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    wmf_datapath #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_opcode       (in_ch.data[0]),
        .i_col          (in_ch.data[6:1]),
        .i_row          (in_ch.data[12:7]),
        .i_pixel_value  (in_ch.data[12+SAMPLE_BITS:13]),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .o_median_value (w_med),
        .o_window_count (w_cnt)
    );

    assign out_ch.data = {w_cnt, w_med};
endmodule

// ===== src/wmf_checker.sv =====
// Port-level checker of the windowed median filter, bound to the top level.
module wmf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [23:0] out_data
);
    a_cnt_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> out_data[23:16] != 8'd0) else $error("zero window count");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result dropped while stalled");
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready |=> !in_ready) else $error("item taken while busy");
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !out_valid) else $error("result after reset");
endmodule

bind windowed_median_filter_2d wmf_checker u_chk (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_ch.data[23:0])
);

// ===== bench/windowed_median_filter_2d_checker.sv =====
// Checker: watches both channels and the register port, predicts medians, compares results.
`timescale 1ns / 100ps
module windowed_median_filter_2d_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [wmf_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [wmf_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    wmf_if                                    in_ch,
    wmf_if                                    out_ch,
    output int                                o_errors,
    output int                                o_pending
);
    typedef struct packed {
        logic [15:0] pixel_value;
        logic [5:0]  row;
        logic [5:0]  col;
        logic        opcode;
    } t_item;

    typedef struct packed {
        logic [7:0]  window_count;
        logic [15:0] median_value;
    } t_result;

    logic signed [15:0] pixel_mem [wmf_pkg::MAX_WIDTH*wmf_pkg::MAX_HEIGHT];
    int unsigned img_w, img_h, half_w, half_h;
    t_result median_q[$];
    int errors;

    assign o_errors  = errors;
    assign o_pending = median_q.size();

    function automatic int unsigned clamp_hi(int unsigned v, int unsigned hi);
        return (v > hi) ? hi : v;
    endfunction

    function automatic t_result window_median(int unsigned cx, int unsigned cy);
        logic signed [15:0] win [225];
        logic signed [15:0] key;
        logic signed [16:0] sum;
        int unsigned x0, x1, y0, y1, n, i, j;
        t_result r;
        n = 0;
        x0 = (cx > half_w) ? cx - half_w : 0;
        y0 = (cy > half_h) ? cy - half_h : 0;
        x1 = clamp_hi(cx + half_w, img_w - 1);
        y1 = clamp_hi(cy + half_h, img_h - 1);
        for (int unsigned b = y0; b <= y1; b++) begin
            for (int unsigned a = x0; a <= x1; a++) begin
                win[n] = pixel_mem[b*wmf_pkg::MAX_WIDTH + a];
                n++;
            end
        end
        for (i = 1; i < n; i++) begin
            key = win[i];
            j = i;
            while (j > 0 && win[j-1] > key) begin
                win[j] = win[j-1];
                j--;
            end
            win[j] = key;
        end
        if (n[0]) begin
            r.median_value = win[n/2];
        end else begin
            sum = 17'(win[n/2-1]) + 17'(win[n/2]);
            r.median_value = 16'(sum >>> 1);
        end
        r.window_count = 8'(n);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_item   it;
        t_result got, want;
        int unsigned cx, cy;
        if (!i_rst_n) begin
            img_w <= 64;
            img_h <= 64;
            half_w <= 1;
            half_h <= 1;
            median_q.delete();
            errors = 0;
        end else begin
            if (i_cfg_we) begin
                case (wmf_pkg::t_reg_idx'(i_cfg_idx))
                    wmf_pkg::REG_IMAGE_WIDTH:  img_w <= (i_cfg_data == 0) ? 1 :
                                               clamp_hi(i_cfg_data, wmf_pkg::MAX_WIDTH);
                    wmf_pkg::REG_IMAGE_HEIGHT: img_h <= (i_cfg_data == 0) ? 1 :
                                               clamp_hi(i_cfg_data, wmf_pkg::MAX_HEIGHT);
                    wmf_pkg::REG_HALF_WIDTH:   half_w <= clamp_hi(i_cfg_data[2:0],
                                                                  wmf_pkg::MAX_HALF);
                    wmf_pkg::REG_HALF_HEIGHT:  half_h <= clamp_hi(i_cfg_data[2:0],
                                                                  wmf_pkg::MAX_HALF);
                    default: ;
                endcase
            end
            if (out_ch.valid && out_ch.ready) begin
                got = out_ch.data;
                if (median_q.size() == 0) begin
                    $error("result item with no query waiting: median_value %0d",
                           $signed(got.median_value));
                    errors++;
                end else begin
                    want = median_q.pop_front();
                    if (got.median_value !== want.median_value) begin
                        $error("median_value expected %0d actual %0d",
                               $signed(want.median_value), $signed(got.median_value));
                        errors++;
                    end
                    if (got.window_count !== want.window_count) begin
                        $error("window_count expected %0d actual %0d",
                               want.window_count, got.window_count);
                        errors++;
                    end
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                it = in_ch.data;
                cx = clamp_hi(it.col, img_w - 1);
                cy = clamp_hi(it.row, img_h - 1);
                if (wmf_pkg::t_opcode'(it.opcode) == wmf_pkg::OP_WRITE)
                    pixel_mem[cy*wmf_pkg::MAX_WIDTH + cx] = it.pixel_value;
                else
                    median_q = {median_q, window_median(cx, cy)};
            end
        end
    end
endmodule

// ===== bench/windowed_median_filter_2d_tb.sv =====
// Testbench top: drives pixel writes, median queries and register settings, reports the verdict.
`timescale 1ns / 100ps
module windowed_median_filter_2d_tb;
    localparam int LIMIT = 6000000;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [wmf_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx;
    logic [wmf_pkg::CFG_DATA_BITS-1:0] i_cfg_data;
    int errors, pending, cycles;
    int idle_pct, stall_pct;
    int unsigned img_w, img_h, half_w, half_h;
    int n_writes, n_queries;
    bit written [wmf_pkg::MAX_WIDTH*wmf_pkg::MAX_HEIGHT];

    wmf_if #(.WIDTH(29)) in_ch  ();
    wmf_if #(.WIDTH(24)) out_ch ();

    windowed_median_filter_2d dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .in_ch      (in_ch),
        .out_ch     (out_ch)
    );

    windowed_median_filter_2d_checker chk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .in_ch      (in_ch),
        .out_ch     (out_ch),
        .o_errors   (errors),
        .o_pending  (pending)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        out_ch.ready = ($urandom_range(99) >= stall_pct);
    end

    function automatic int unsigned clamp_hi(int unsigned v, int unsigned hi);
        return (v > hi) ? hi : v;
    endfunction

    // mostly near the origin, now and then the far edge
    function automatic int unsigned pick_coord();
        return ($urandom_range(15) == 0) ? 63 : $urandom_range(3);
    endfunction

    task automatic send_item(wmf_pkg::t_opcode op, int unsigned col, int unsigned row,
                             logic [15:0] pix);
        @(negedge i_clk);
        while ($urandom_range(99) < idle_pct) begin
            in_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid = 1'b1;
        in_ch.data  = {pix, 6'(row), 6'(col), op};
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        if (op == wmf_pkg::OP_WRITE) begin
            written[clamp_hi(row, img_h-1)*wmf_pkg::MAX_WIDTH + clamp_hi(col, img_w-1)] = 1'b1;
            n_writes++;
        end else begin
            n_queries++;
        end
    endtask

    // write any uncovered pixel of the window and now and then a covered one, then query it
    task automatic query_filled(int unsigned col, int unsigned row);
        int unsigned cx, cy, x0, x1, y0, y1;
        cx = clamp_hi(col, img_w-1);
        cy = clamp_hi(row, img_h-1);
        x0 = (cx > half_w) ? cx - half_w : 0;
        y0 = (cy > half_h) ? cy - half_h : 0;
        x1 = clamp_hi(cx + half_w, img_w-1);
        y1 = clamp_hi(cy + half_h, img_h-1);
        for (int unsigned b = y0; b <= y1; b++)
            for (int unsigned a = x0; a <= x1; a++)
                if (!written[b*wmf_pkg::MAX_WIDTH + a] || $urandom_range(49) == 0)
                    send_item(wmf_pkg::OP_WRITE, a, b, 16'($urandom));
        send_item(wmf_pkg::OP_QUERY, col, row, 16'($urandom));
    endtask

    task automatic settle_and_config(int unsigned w, int unsigned h,
                                     int unsigned hw, int unsigned hh);
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (30) @(negedge i_clk);
        for (int k = 0; k < 4; k++) begin
            i_cfg_we  = 1'b1;
            i_cfg_idx = k[wmf_pkg::CFG_IDX_BITS-1:0];
            case (wmf_pkg::t_reg_idx'(k))
                wmf_pkg::REG_IMAGE_WIDTH:  i_cfg_data = 7'(w);
                wmf_pkg::REG_IMAGE_HEIGHT: i_cfg_data = 7'(h);
                wmf_pkg::REG_HALF_WIDTH:   i_cfg_data = {4'($urandom), 3'(hw)};
                default:                   i_cfg_data = {4'($urandom), 3'(hh)};
            endcase
            @(negedge i_clk);
        end
        i_cfg_we = 1'b0;
        img_w  = (w == 0) ? 1 : clamp_hi(w, wmf_pkg::MAX_WIDTH);
        img_h  = (h == 0) ? 1 : clamp_hi(h, wmf_pkg::MAX_HEIGHT);
        half_w = hw;
        half_h = hh;
    endtask

    task automatic random_items(int count);
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(9) < 7)
                query_filled(pick_coord(), pick_coord());
            else
                send_item(wmf_pkg::OP_WRITE, $urandom_range(63), $urandom_range(63),
                          16'($urandom));
        end
    endtask

    initial begin
        cycles = 0;
        idle_pct = 0;
        stall_pct = 0;
        n_writes = 0;
        n_queries = 0;
        img_w = 64;
        img_h = 64;
        half_w = 1;
        half_h = 1;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        send_item(wmf_pkg::OP_WRITE, 0, 0, 16'h8000);
        send_item(wmf_pkg::OP_WRITE, 1, 0, 16'h8000);
        send_item(wmf_pkg::OP_WRITE, 0, 1, 16'h7fff);
        send_item(wmf_pkg::OP_WRITE, 1, 1, 16'hffff);
        send_item(wmf_pkg::OP_QUERY, 0, 0, 16'hffff);
        send_item(wmf_pkg::OP_WRITE, 63, 63, 16'h7fff);
        send_item(wmf_pkg::OP_WRITE, 62, 63, 16'h7fff);
        send_item(wmf_pkg::OP_WRITE, 63, 62, 16'h0000);
        send_item(wmf_pkg::OP_WRITE, 62, 62, 16'h0001);
        send_item(wmf_pkg::OP_QUERY, 63, 63, 16'h0000);
        query_filled(2, 2);
        random_items(15);

        idle_pct = 54;
        settle_and_config(0, 1, 0, 0);
        send_item(wmf_pkg::OP_WRITE, 63, 63, 16'h8000);
        send_item(wmf_pkg::OP_QUERY, 63, 63, 16'h7fff);
        send_item(wmf_pkg::OP_QUERY, 0, 0, 16'h0000);
        random_items(8);
        settle_and_config(127, 1, 7, 0);
        random_items(8);

        idle_pct = 0;
        stall_pct = 54;
        settle_and_config(6, 6, 7, 7);
        query_filled(3, 3);
        query_filled(0, 63);
        random_items(6);

        idle_pct = 27;
        stall_pct = 27;
        settle_and_config(100, 20, 3, 5);
        random_items(8);
        settle_and_config($urandom_range(1, 64), $urandom_range(1, 64),
                          $urandom_range(0, 2), $urandom_range(0, 2));
        random_items(8);
        settle_and_config(1, 64, 2, 7);
        random_items(5);

        @(negedge i_clk);
        in_ch.valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (100) @(negedge i_clk);
        $display("Covered %0d pixel writes and %0d median queries over several image sizes,",
                 n_writes, n_queries);
        $display("window extents 0..7 and four sender/receiver idling patterns.");
        if (errors == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule

// ===== windowed_median_filter_2d.f =====
src/wmf_pkg.sv
src/wmf_if.sv
src/wmf_ctrl.sv
src/wmf_datapath.sv
src/windowed_median_filter_2d.sv
src/wmf_checker.sv
bench/windowed_median_filter_2d_checker.sv
bench/windowed_median_filter_2d_tb.sv
